// ----- rtl/mtep_pkg.sv -----
// Package: types, codes and a decode helper shared by the track event parser.
`default_nettype none

package mtep_pkg;

    localparam int TICK_BITS_DEF = 48;
    localparam int EVENT_TICK_W  = 48;
    localparam int VLQ_W         = 28;
    localparam int VLQ_CNT_W     = 3;
    localparam int TEMPO_W       = 24;
    localparam int COUNT_W       = 32;

    localparam logic [7:0]         STATUS_META  = 8'hFF;
    localparam logic [7:0]         STATUS_SYSEX = 8'hF0;
    localparam logic [7:0]         STATUS_ESC   = 8'hF7;
    localparam logic [7:0]         META_TEMPO   = 8'h51;
    localparam logic [VLQ_W-1:0]   TEMPO_LEN    = VLQ_W'(3);
    localparam logic [VLQ_CNT_W-1:0] VLQ_MAX_CNT = VLQ_CNT_W'(4);

    localparam logic [3:0] NIB_NOTE_OFF = 4'h8;
    localparam logic [3:0] NIB_NOTE_ON  = 4'h9;
    localparam logic [3:0] NIB_CONTROL  = 4'hB;
    localparam logic [3:0] NIB_PROGRAM  = 4'hC;
    localparam logic [3:0] NIB_CH_PRESS = 4'hD;
    localparam logic [3:0] NIB_BEND     = 4'hE;
    localparam logic [3:0] NIB_SYSTEM   = 4'hF;

    typedef enum logic [3:0] {
        PH_DELTA,
        PH_STATUS,
        PH_META_TYPE,
        PH_META_LEN,
        PH_META_SKIP,
        PH_TEMPO,
        PH_SYSEX_LEN,
        PH_SYSEX_SKIP,
        PH_DATA1,
        PH_DATA2
    } t_phase;

    typedef enum logic [2:0] {
        KIND_NOTE_OFF,
        KIND_NOTE_ON,
        KIND_CONTROL,
        KIND_PROGRAM,
        KIND_BEND,
        KIND_TEMPO,
        KIND_END,
        KIND_ERROR
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE,
        ERR_VLQ_SHORT,
        ERR_VLQ_LONG,
        ERR_NO_RUNNING,
        ERR_TICK_OVF,
        ERR_EVENT_TRUNC,
        ERR_META_TRUNC,
        ERR_META_OVERRUN,
        ERR_SYSEX_OVERRUN,
        ERR_SYSTEM,
        ERR_CHAN_TRUNC,
        ERR_DATA_HIGH
    } t_err;

    typedef struct packed {
        logic  valid;
        t_kind kind;
    } t_chan_kind;

    typedef struct packed {
        t_kind                   result_kind;
        logic [3:0]              channel_number;
        logic [6:0]              first_value;
        logic [6:0]              second_value;
        logic [TEMPO_W-1:0]      tempo_value;
        logic [EVENT_TICK_W-1:0] event_tick;
        logic [COUNT_W-1:0]      event_number;
        t_err                    error_code;
        logic                    track_end;
    } t_result;

    function automatic t_chan_kind chan_kind(input logic [7:0] status, input logic [6:0] second);
        t_chan_kind ck;
        ck.valid = 1'b1;
        ck.kind  = KIND_NOTE_OFF;
        unique case (status[7:4])
            NIB_NOTE_OFF: ck.kind = KIND_NOTE_OFF;
            NIB_NOTE_ON:  ck.kind = (second == 7'd0) ? KIND_NOTE_OFF : KIND_NOTE_ON;
            NIB_CONTROL:  ck.kind = KIND_CONTROL;
            NIB_PROGRAM:  ck.kind = KIND_PROGRAM;
            NIB_BEND:     ck.kind = KIND_BEND;
            default:      ck.valid = 1'b0;
        endcase
        return ck;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/midi_track_event_parser_unit.sv -----
// Top level of the track event parser: byte input, parser, result register and skid stage.
//
//   channel   | direction | handshake          | word
//   ----------+-----------+--------------------+----------------------------------------
//   byte in   | in        | i_valid / o_ready  | i_data_byte, i_last_byte
//   result    | out       | o_valid / i_ready  | o_result_kind ... o_track_end
//
// One byte is taken per cycle while o_ready is high; its result, if any, shows the next cycle unless one is held.
// The parser state updates in the cycle the byte is taken; one result register plus a
// one-entry skid stage let a byte enter while an earlier result is still held.
// o_ready drops only while the skid stage is full.
// Reset clears parser state and both output stages; the last byte of a track clears
// the parser state the same way.
`default_nettype none

module midi_track_event_parser_unit #(
    parameter int TICK_BITS = mtep_pkg::TICK_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_last_byte,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [2:0]       o_result_kind,
    output logic [3:0]       o_channel_number,
    output logic [6:0]       o_first_value,
    output logic [6:0]       o_second_value,
    output logic [23:0]      o_tempo_value,
    output logic [47:0]      o_event_tick,
    output logic [31:0]      o_event_number,
    output logic [3:0]       o_error_code,
    output logic             o_track_end
);

    logic               accept;
    logic               res_valid;
    mtep_pkg::t_result  res;
    logic               load_out;

    logic               r_out_valid;
    mtep_pkg::t_result  r_out;
    logic               r_skid_valid;
    mtep_pkg::t_result  r_skid;

    assign o_ready  = !r_skid_valid;
    assign accept   = i_valid && o_ready;
    assign load_out = !r_out_valid || i_ready;

    mtep_parser #(
        .TICK_BITS (TICK_BITS)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (load_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= res_valid;
            end
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (!load_out && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_out.result_kind;
    assign o_channel_number = r_out.channel_number;
    assign o_first_value    = r_out.first_value;
    assign o_second_value   = r_out.second_value;
    assign o_tempo_value    = r_out.tempo_value;
    assign o_event_tick     = r_out.event_tick;
    assign o_event_number   = r_out.event_number;
    assign o_error_code     = r_out.error_code;
    assign o_track_end      = r_out.track_end;

endmodule

`default_nettype wire

// ----- rtl/mtep_parser.sv -----
// Parser state registers and per-byte decode of the track chunk.
`default_nettype none

module mtep_parser #(
    parameter int TICK_BITS = mtep_pkg::TICK_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [7:0]       i_data_byte,
    input  wire logic             i_last_byte,
    output logic                  o_res_valid,
    output mtep_pkg::t_result     o_res
);

    mtep_pkg::t_phase                       r_phase, n_phase;
    logic [mtep_pkg::VLQ_W-1:0]             r_vlq_acc, n_vlq_acc;
    logic [mtep_pkg::VLQ_CNT_W-1:0]         r_vlq_cnt, n_vlq_cnt;
    logic [TICK_BITS-1:0]                   r_tick, n_tick;
    logic [7:0]                             r_running, n_running;
    logic [7:0]                             r_ev_status, n_ev_status;
    logic [6:0]                             r_held, n_held;
    logic [mtep_pkg::VLQ_W-1:0]             r_skip, n_skip;
    logic                                   r_meta_tempo, n_meta_tempo;
    logic [mtep_pkg::TEMPO_W-1:0]           r_tempo, n_tempo;
    logic [mtep_pkg::COUNT_W-1:0]           r_count, n_count;
    logic                                   r_err_latched, n_err_latched;

    logic [mtep_pkg::VLQ_W-1:0]             vlq_acc_take;
    logic [mtep_pkg::VLQ_CNT_W-1:0]         vlq_cnt_take;
    logic                                   vlq_done, vlq_long;
    logic [TICK_BITS:0]                     tick_sum;
    logic [63:0]                            tick_ext;

    mtep_pkg::t_err                         err;
    mtep_pkg::t_chan_kind                   ev_kind;
    logic [6:0]                             v1, v2;
    logic [mtep_pkg::TEMPO_W-1:0]           tempo_out;
    logic                                   done, data1, one_byte, clear;
    logic                                   res_valid;
    mtep_pkg::t_kind                        res_kind;

    assign vlq_acc_take = {r_vlq_acc[mtep_pkg::VLQ_W-8:0], i_data_byte[6:0]};
    assign vlq_cnt_take = r_vlq_cnt + mtep_pkg::VLQ_CNT_W'(1);
    assign vlq_done     = !i_data_byte[7];
    assign vlq_long     = (vlq_cnt_take >= mtep_pkg::VLQ_MAX_CNT);
    assign tick_sum     = {1'b0, r_tick} + (TICK_BITS+1)'(vlq_acc_take);

    // next state
    always_comb begin
        n_phase       = r_phase;
        n_vlq_acc     = r_vlq_acc;
        n_vlq_cnt     = r_vlq_cnt;
        n_tick        = r_tick;
        n_running     = r_running;
        n_ev_status   = r_ev_status;
        n_held        = r_held;
        n_skip        = r_skip;
        n_meta_tempo  = r_meta_tempo;
        n_tempo       = r_tempo;
        n_count       = r_count;
        n_err_latched = r_err_latched;
        err           = mtep_pkg::ERR_NONE;
        ev_kind       = '0;
        v1            = 7'd0;
        v2            = 7'd0;
        tempo_out     = '0;
        done          = 1'b0;
        data1         = 1'b0;
        one_byte      = 1'b0;
        res_valid     = 1'b0;
        res_kind      = mtep_pkg::KIND_END;

        if (r_err_latched) begin
            res_valid = i_last_byte;
        end else begin
            unique case (r_phase)
                mtep_pkg::PH_DELTA: begin
                    n_vlq_acc = vlq_acc_take;
                    n_vlq_cnt = vlq_cnt_take;
                    if (vlq_done) begin
                        if (tick_sum[TICK_BITS]) begin
                            err = mtep_pkg::ERR_TICK_OVF;
                        end else begin
                            n_tick = tick_sum[TICK_BITS-1:0];
                            if (i_last_byte) err = mtep_pkg::ERR_EVENT_TRUNC;
                            else n_phase = mtep_pkg::PH_STATUS;
                        end
                    end else if (vlq_long) begin
                        err = mtep_pkg::ERR_VLQ_LONG;
                    end else if (i_last_byte) begin
                        err = mtep_pkg::ERR_VLQ_SHORT;
                    end
                end
                mtep_pkg::PH_STATUS: begin
                    priority if (!i_data_byte[7]) begin
                        if (r_running == 8'd0) begin
                            err = mtep_pkg::ERR_NO_RUNNING;
                        end else begin
                            n_ev_status = r_running;
                            data1 = 1'b1;
                        end
                    end else if (i_data_byte == mtep_pkg::STATUS_META) begin
                        n_running = 8'd0;
                        if (i_last_byte) err = mtep_pkg::ERR_META_TRUNC;
                        else n_phase = mtep_pkg::PH_META_TYPE;
                    end else if (i_data_byte == mtep_pkg::STATUS_SYSEX
                                 || i_data_byte == mtep_pkg::STATUS_ESC) begin
                        n_running = 8'd0;
                        n_vlq_acc = '0;
                        n_vlq_cnt = '0;
                        if (i_last_byte) err = mtep_pkg::ERR_VLQ_SHORT;
                        else n_phase = mtep_pkg::PH_SYSEX_LEN;
                    end else if (i_data_byte[7:4] == mtep_pkg::NIB_SYSTEM) begin
                        err = mtep_pkg::ERR_SYSTEM;
                    end else begin
                        n_running   = i_data_byte;
                        n_ev_status = i_data_byte;
                        if (i_last_byte) err = mtep_pkg::ERR_CHAN_TRUNC;
                        else n_phase = mtep_pkg::PH_DATA1;
                    end
                end
                mtep_pkg::PH_DATA1: begin
                    data1 = 1'b1;
                end
                mtep_pkg::PH_DATA2: begin
                    if (i_data_byte[7]) begin
                        err = mtep_pkg::ERR_DATA_HIGH;
                    end else begin
                        ev_kind = mtep_pkg::chan_kind(r_ev_status, i_data_byte[6:0]);
                        v1   = r_held;
                        v2   = i_data_byte[6:0];
                        done = 1'b1;
                    end
                end
                mtep_pkg::PH_META_TYPE: begin
                    n_meta_tempo = (i_data_byte == mtep_pkg::META_TEMPO);
                    n_vlq_acc    = '0;
                    n_vlq_cnt    = '0;
                    if (i_last_byte) err = mtep_pkg::ERR_VLQ_SHORT;
                    else n_phase = mtep_pkg::PH_META_LEN;
                end
                mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
                    n_vlq_acc = vlq_acc_take;
                    n_vlq_cnt = vlq_cnt_take;
                    if (vlq_done) begin
                        priority if (vlq_acc_take == '0) begin
                            done = 1'b1;
                        end else if (i_last_byte) begin
                            err = (r_phase == mtep_pkg::PH_META_LEN)
                                ? mtep_pkg::ERR_META_OVERRUN : mtep_pkg::ERR_SYSEX_OVERRUN;
                        end else begin
                            n_skip = vlq_acc_take;
                            priority if (r_phase == mtep_pkg::PH_META_LEN && r_meta_tempo
                                         && vlq_acc_take == mtep_pkg::TEMPO_LEN) begin
                                n_tempo = '0;
                                n_phase = mtep_pkg::PH_TEMPO;
                            end else if (r_phase == mtep_pkg::PH_META_LEN) begin
                                n_phase = mtep_pkg::PH_META_SKIP;
                            end else begin
                                n_phase = mtep_pkg::PH_SYSEX_SKIP;
                            end
                        end
                    end else if (vlq_long) begin
                        err = mtep_pkg::ERR_VLQ_LONG;
                    end else if (i_last_byte) begin
                        err = mtep_pkg::ERR_VLQ_SHORT;
                    end
                end
                mtep_pkg::PH_META_SKIP, mtep_pkg::PH_SYSEX_SKIP, mtep_pkg::PH_TEMPO: begin
                    if (r_phase == mtep_pkg::PH_TEMPO) begin
                        n_tempo = {r_tempo[mtep_pkg::TEMPO_W-9:0], i_data_byte};
                    end
                    n_skip = r_skip - mtep_pkg::VLQ_W'(1);
                    if (n_skip == '0) begin
                        done = 1'b1;
                        if (r_phase == mtep_pkg::PH_TEMPO) begin
                            ev_kind.valid = 1'b1;
                            ev_kind.kind  = mtep_pkg::KIND_TEMPO;
                            tempo_out     = n_tempo;
                        end
                    end else if (i_last_byte) begin
                        err = (r_phase == mtep_pkg::PH_SYSEX_SKIP)
                            ? mtep_pkg::ERR_SYSEX_OVERRUN : mtep_pkg::ERR_META_OVERRUN;
                    end
                end
                default: begin
                    n_phase   = mtep_pkg::PH_DELTA;
                    n_vlq_acc = '0;
                    n_vlq_cnt = '0;
                end
            endcase

            if (data1) begin
                one_byte = (n_ev_status[7:4] == mtep_pkg::NIB_PROGRAM)
                        || (n_ev_status[7:4] == mtep_pkg::NIB_CH_PRESS);
                priority if (!one_byte && i_last_byte) begin
                    err = mtep_pkg::ERR_CHAN_TRUNC;
                end else if (i_data_byte[7]) begin
                    err = mtep_pkg::ERR_DATA_HIGH;
                end else if (one_byte) begin
                    ev_kind = mtep_pkg::chan_kind(n_ev_status, 7'd0);
                    v1   = i_data_byte[6:0];
                    done = 1'b1;
                end else begin
                    n_held  = i_data_byte[6:0];
                    n_phase = mtep_pkg::PH_DATA2;
                end
            end

            if (err != mtep_pkg::ERR_NONE) begin
                res_valid = 1'b1;
                res_kind  = mtep_pkg::KIND_ERROR;
                if (!i_last_byte) n_err_latched = 1'b1;
            end else if (done) begin
                n_phase   = mtep_pkg::PH_DELTA;
                n_vlq_acc = '0;
                n_vlq_cnt = '0;
                if (ev_kind.valid) begin
                    res_valid = 1'b1;
                    res_kind  = ev_kind.kind;
                    n_count   = r_count + mtep_pkg::COUNT_W'(1);
                end else if (i_last_byte) begin
                    res_valid = 1'b1;
                end
            end else if (i_last_byte) begin
                res_valid = 1'b1;
                res_kind  = mtep_pkg::KIND_ERROR;
                err       = mtep_pkg::ERR_EVENT_TRUNC;
            end
        end

        clear = i_last_byte;
    end

    // result word
    always_comb begin
        tick_ext             = 64'(n_tick);
        o_res_valid          = i_accept && res_valid;
        o_res                = '0;
        o_res.result_kind    = res_kind;
        o_res.event_tick     = tick_ext[mtep_pkg::EVENT_TICK_W-1:0];
        o_res.event_number   = r_count;
        o_res.track_end      = i_last_byte;
        o_res.error_code     = err;
        if (res_kind != mtep_pkg::KIND_ERROR && res_kind != mtep_pkg::KIND_END) begin
            o_res.first_value  = v1;
            o_res.second_value = v2;
            o_res.tempo_value  = tempo_out;
            if (res_kind != mtep_pkg::KIND_TEMPO) begin
                o_res.channel_number = n_ev_status[3:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && clear)) begin
            r_phase       <= mtep_pkg::PH_DELTA;
            r_vlq_acc     <= '0;
            r_vlq_cnt     <= '0;
            r_tick        <= '0;
            r_running     <= '0;
            r_ev_status   <= '0;
            r_held        <= '0;
            r_skip        <= '0;
            r_meta_tempo  <= 1'b0;
            r_tempo       <= '0;
            r_count       <= '0;
            r_err_latched <= 1'b0;
        end else if (i_accept) begin
            r_phase       <= n_phase;
            r_vlq_acc     <= n_vlq_acc;
            r_vlq_cnt     <= n_vlq_cnt;
            r_tick        <= n_tick;
            r_running     <= n_running;
            r_ev_status   <= n_ev_status;
            r_held        <= n_held;
            r_skip        <= n_skip;
            r_meta_tempo  <= n_meta_tempo;
            r_tempo       <= n_tempo;
            r_count       <= n_count;
            r_err_latched <= n_err_latched;
        end
    end

endmodule

`default_nettype wire

// ----- bench/midi_track_event_parser_unit_test.sv -----
// Testbench for the track event parser: scripted bytes, random tracks, byte-level predictor.
`timescale 1ns / 100ps

module midi_track_event_parser_unit_test;

    localparam int TICK_BITS = 32;
    localparam logic [63:0] TICK_MAX = (64'd1 << TICK_BITS) - 64'd1;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 180;
    localparam int SND_IDLE [3] = '{21, 80, 0};
    localparam int RCV_IDLE [3] = '{80, 21, 0};
    localparam logic [7:0] META_END_OF_TRACK = 8'h2F;

    typedef enum logic [1:0] {
        VLQ_MORE,
        VLQ_DONE,
        VLQ_LONG,
        VLQ_SHORT
    } t_vlq_step;

    typedef struct packed {
        logic [7:0]      data;
        logic            last;
        logic            typed;
        mtep_pkg::t_kind kind;
        mtep_pkg::t_err  err;
    } t_script_row;

    localparam t_script_row SCRIPT [29] = '{
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h40, 1'b0, 1'b1, mtep_pkg::KIND_ERROR, mtep_pkg::ERR_NO_RUNNING},
        '{8'h55, 1'b1, 1'b1, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h9F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hB3, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hE0, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hC5, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h7F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h51, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h03, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'hFF, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h2F, 1'b0, 1'b0, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE},
        '{8'h00, 1'b1, 1'b1, mtep_pkg::KIND_END,   mtep_pkg::ERR_NONE}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [2:0]  o_result_kind;
    logic [3:0]  o_channel_number;
    logic [6:0]  o_first_value;
    logic [6:0]  o_second_value;
    logic [23:0] o_tempo_value;
    logic [47:0] o_event_tick;
    logic [31:0] o_event_number;
    logic [3:0]  o_error_code;
    logic        o_track_end;

    logic            want_typed;
    mtep_pkg::t_kind want_kind;
    mtep_pkg::t_err  want_err;

    int snd_idle = SND_IDLE[0];
    int rcv_idle = RCV_IDLE[0];
    int n_fail = 0;
    int n_sent = 0;
    int stall_cycles = 0;

    mtep_pkg::t_result pending_events [$];
    logic [7:0]        track_bytes [$];
    logic [7:0]        gen_running;

    mtep_pkg::t_phase ps_phase;
    logic [27:0]      ps_vlq;
    logic [2:0]       ps_vlq_n;
    logic [63:0]      ps_tick;
    logic [7:0]       ps_running;
    logic [7:0]       ps_status;
    logic [7:0]       ps_held;
    logic [27:0]      ps_left;
    logic [7:0]       ps_meta;
    logic [23:0]      ps_tempo;
    logic [31:0]      ps_emitted;
    bit               ps_halted;

    midi_track_event_parser_unit #(
        .TICK_BITS(TICK_BITS)
    ) u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_data_byte      (i_data_byte),
        .i_last_byte      (i_last_byte),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_result_kind    (o_result_kind),
        .o_channel_number (o_channel_number),
        .o_first_value    (o_first_value),
        .o_second_value   (o_second_value),
        .o_tempo_value    (o_tempo_value),
        .o_event_tick     (o_event_tick),
        .o_event_number   (o_event_number),
        .o_error_code     (o_error_code),
        .o_track_end      (o_track_end)
    );

    always #6 i_clk = ~i_clk;

    function automatic void clear_parser();
        ps_phase   = mtep_pkg::PH_DELTA;
        ps_vlq     = '0;
        ps_vlq_n   = '0;
        ps_tick    = '0;
        ps_running = '0;
        ps_status  = '0;
        ps_held    = '0;
        ps_left    = '0;
        ps_meta    = '0;
        ps_tempo   = '0;
        ps_emitted = '0;
        ps_halted  = 1'b0;
    endfunction

    function automatic t_vlq_step take_vlq(input logic [7:0] b, input logic lst);
        ps_vlq   = {ps_vlq[20:0], b[6:0]};
        ps_vlq_n = ps_vlq_n + 3'd1;
        if (!b[7]) return VLQ_DONE;
        if (ps_vlq_n >= mtep_pkg::VLQ_MAX_CNT) return VLQ_LONG;
        if (lst) return VLQ_SHORT;
        return VLQ_MORE;
    endfunction

    function automatic bit decode_channel(input logic [7:0] st, input logic [6:0] sec,
                                          output mtep_pkg::t_kind k);
        k = mtep_pkg::KIND_NOTE_OFF;
        case (st[7:4])
            mtep_pkg::NIB_NOTE_OFF: return 1'b1;
            mtep_pkg::NIB_NOTE_ON: begin
                if (sec != 7'd0) k = mtep_pkg::KIND_NOTE_ON;
                return 1'b1;
            end
            mtep_pkg::NIB_CONTROL: begin
                k = mtep_pkg::KIND_CONTROL;
                return 1'b1;
            end
            mtep_pkg::NIB_PROGRAM: begin
                k = mtep_pkg::KIND_PROGRAM;
                return 1'b1;
            end
            mtep_pkg::NIB_BEND: begin
                k = mtep_pkg::KIND_BEND;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic mtep_pkg::t_result make_result(input mtep_pkg::t_kind k,
                                                      input logic [3:0] ch,
                                                      input logic [6:0] a, input logic [6:0] c,
                                                      input logic [23:0] t,
                                                      input mtep_pkg::t_err e,
                                                      input logic te);
        mtep_pkg::t_result r;
        r.result_kind    = k;
        r.channel_number = ch;
        r.first_value    = a;
        r.second_value   = c;
        r.tempo_value    = t;
        r.event_tick     = ps_tick[47:0];
        r.event_number   = ps_emitted;
        r.error_code     = e;
        r.track_end      = te;
        return r;
    endfunction

    function automatic bit parse_track_byte(input logic [7:0] b, input logic lst,
                                            output mtep_pkg::t_result res);
        mtep_pkg::t_kind kind;
        mtep_pkg::t_err  err;
        t_vlq_step       vr;
        bit              has_kind, done, data1, one, meta;
        logic [6:0]      v1, v2;
        logic [23:0]     tempo;
        logic [3:0]      ch;
        kind     = mtep_pkg::KIND_END;
        err      = mtep_pkg::ERR_NONE;
        has_kind = 1'b0;
        done     = 1'b0;
        data1    = 1'b0;
        v1       = '0;
        v2       = '0;
        tempo    = '0;
        res      = '0;
        if (ps_halted) begin
            if (!lst) return 1'b0;
            res = make_result(mtep_pkg::KIND_END, '0, '0, '0, '0, mtep_pkg::ERR_NONE, 1'b1);
            clear_parser();
            return 1'b1;
        end
        case (ps_phase)
            mtep_pkg::PH_DELTA: begin
                vr = take_vlq(b, lst);
                if (vr == VLQ_DONE) begin
                    if ({36'd0, ps_vlq} > TICK_MAX - ps_tick) begin
                        err = mtep_pkg::ERR_TICK_OVF;
                    end else begin
                        ps_tick = ps_tick + {36'd0, ps_vlq};
                        if (lst) err = mtep_pkg::ERR_EVENT_TRUNC;
                        else ps_phase = mtep_pkg::PH_STATUS;
                    end
                end else if (vr == VLQ_LONG) begin
                    err = mtep_pkg::ERR_VLQ_LONG;
                end else if (vr == VLQ_SHORT) begin
                    err = mtep_pkg::ERR_VLQ_SHORT;
                end
            end
            mtep_pkg::PH_STATUS: begin
                if (!b[7]) begin
                    if (ps_running == 8'h00) begin
                        err = mtep_pkg::ERR_NO_RUNNING;
                    end else begin
                        ps_status = ps_running;
                        data1 = 1'b1;
                    end
                end else if (b == mtep_pkg::STATUS_META) begin
                    ps_running = '0;
                    if (lst) err = mtep_pkg::ERR_META_TRUNC;
                    else ps_phase = mtep_pkg::PH_META_TYPE;
                end else if (b == mtep_pkg::STATUS_SYSEX || b == mtep_pkg::STATUS_ESC) begin
                    ps_running = '0;
                    ps_vlq = '0;
                    ps_vlq_n = '0;
                    if (lst) err = mtep_pkg::ERR_VLQ_SHORT;
                    else ps_phase = mtep_pkg::PH_SYSEX_LEN;
                end else if (b[7:4] == mtep_pkg::NIB_SYSTEM) begin
                    err = mtep_pkg::ERR_SYSTEM;
                end else begin
                    ps_running = b;
                    ps_status = b;
                    if (lst) err = mtep_pkg::ERR_CHAN_TRUNC;
                    else ps_phase = mtep_pkg::PH_DATA1;
                end
            end
            mtep_pkg::PH_DATA1: data1 = 1'b1;
            mtep_pkg::PH_DATA2: begin
                if (b[7]) begin
                    err = mtep_pkg::ERR_DATA_HIGH;
                end else begin
                    has_kind = decode_channel(ps_status, b[6:0], kind);
                    v1 = ps_held[6:0];
                    v2 = b[6:0];
                    done = 1'b1;
                end
            end
            mtep_pkg::PH_META_TYPE: begin
                ps_meta = b;
                ps_vlq = '0;
                ps_vlq_n = '0;
                if (lst) err = mtep_pkg::ERR_VLQ_SHORT;
                else ps_phase = mtep_pkg::PH_META_LEN;
            end
            mtep_pkg::PH_META_LEN, mtep_pkg::PH_SYSEX_LEN: begin
                meta = (ps_phase == mtep_pkg::PH_META_LEN);
                vr = take_vlq(b, lst);
                if (vr == VLQ_DONE) begin
                    if (ps_vlq == '0) begin
                        done = 1'b1;
                    end else if (lst) begin
                        err = meta ? mtep_pkg::ERR_META_OVERRUN : mtep_pkg::ERR_SYSEX_OVERRUN;
                    end else begin
                        ps_left = ps_vlq;
                        if (meta && ps_meta == mtep_pkg::META_TEMPO
                            && ps_vlq == mtep_pkg::TEMPO_LEN) begin
                            ps_tempo = '0;
                            ps_phase = mtep_pkg::PH_TEMPO;
                        end else begin
                            ps_phase = meta ? mtep_pkg::PH_META_SKIP : mtep_pkg::PH_SYSEX_SKIP;
                        end
                    end
                end else if (vr == VLQ_LONG) begin
                    err = mtep_pkg::ERR_VLQ_LONG;
                end else if (vr == VLQ_SHORT) begin
                    err = mtep_pkg::ERR_VLQ_SHORT;
                end
            end
            default: begin
                if (ps_phase == mtep_pkg::PH_TEMPO) ps_tempo = {ps_tempo[15:0], b};
                ps_left = ps_left - 28'd1;
                if (ps_left == '0) begin
                    done = 1'b1;
                    if (ps_phase == mtep_pkg::PH_TEMPO) begin
                        has_kind = 1'b1;
                        kind = mtep_pkg::KIND_TEMPO;
                        tempo = ps_tempo;
                    end
                end else if (lst) begin
                    err = (ps_phase == mtep_pkg::PH_SYSEX_SKIP)
                        ? mtep_pkg::ERR_SYSEX_OVERRUN : mtep_pkg::ERR_META_OVERRUN;
                end
            end
        endcase

        if (data1) begin
            one = (ps_status[7:4] == mtep_pkg::NIB_PROGRAM
                   || ps_status[7:4] == mtep_pkg::NIB_CH_PRESS);
            if (!one && lst) begin
                err = mtep_pkg::ERR_CHAN_TRUNC;
            end else if (b[7]) begin
                err = mtep_pkg::ERR_DATA_HIGH;
            end else if (one) begin
                has_kind = decode_channel(ps_status, 7'd0, kind);
                v1 = b[6:0];
                done = 1'b1;
            end else begin
                ps_held = b;
                ps_phase = mtep_pkg::PH_DATA2;
            end
        end

        if (err != mtep_pkg::ERR_NONE) begin
            res = make_result(mtep_pkg::KIND_ERROR, '0, '0, '0, '0, err, lst);
            if (lst) clear_parser();
            else ps_halted = 1'b1;
            return 1'b1;
        end
        if (done) begin
            ps_phase = mtep_pkg::PH_DELTA;
            ps_vlq = '0;
            ps_vlq_n = '0;
            if (has_kind) begin
                ch = (kind == mtep_pkg::KIND_TEMPO) ? 4'd0 : ps_status[3:0];
                res = make_result(kind, ch, v1, v2, tempo, mtep_pkg::ERR_NONE, lst);
                ps_emitted = ps_emitted + 32'd1;
                if (lst) clear_parser();
                return 1'b1;
            end
            if (lst) begin
                res = make_result(mtep_pkg::KIND_END, '0, '0, '0, '0, mtep_pkg::ERR_NONE, 1'b1);
                clear_parser();
                return 1'b1;
            end
            return 1'b0;
        end
        if (lst) begin
            res = make_result(mtep_pkg::KIND_ERROR, '0, '0, '0, '0,
                              mtep_pkg::ERR_EVENT_TRUNC, 1'b1);
            clear_parser();
            return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge i_clk) begin
        mtep_pkg::t_result res;
        mtep_pkg::t_result exp_word;
        bit                has;
        if (!i_rst_n) begin
            clear_parser();
        end else begin
            if (i_valid && o_ready) begin
                has = parse_track_byte(i_data_byte, i_last_byte, res);
                if (has) pending_events.push_front(res);
                if (want_typed) begin
                    if (!has) begin
                        $error("result_kind: expected %0d, actual no result", want_kind);
                        n_fail++;
                    end else begin
                        check_field("result_kind", want_kind, res.result_kind);
                        check_field("error_code", want_err, res.error_code);
                    end
                end
            end
            if (o_valid && i_ready) begin
                if (pending_events.size() == 0) begin
                    $error("result word: expected none, actual kind %0d", o_result_kind);
                    n_fail++;
                end else begin
                    exp_word = pending_events.pop_back();
                    check_field("result_kind", exp_word.result_kind, o_result_kind);
                    check_field("channel_number", exp_word.channel_number, o_channel_number);
                    check_field("first_value", exp_word.first_value, o_first_value);
                    check_field("second_value", exp_word.second_value, o_second_value);
                    check_field("tempo_value", exp_word.tempo_value, o_tempo_value);
                    check_field("event_tick", exp_word.event_tick, o_event_tick);
                    check_field("event_number", exp_word.event_number, o_event_number);
                    check_field("error_code", exp_word.error_code, o_error_code);
                    check_field("track_end", exp_word.track_end, o_track_end);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) stall_cycles <= 0;
        else stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_ready <= ($urandom_range(0, 99) >= rcv_idle);
    end

    task automatic send_byte(input logic [7:0] b, input logic lst, input logic typed,
                             input mtep_pkg::t_kind k, input mtep_pkg::t_err e);
        while ($urandom_range(0, 99) < snd_idle) begin
            i_valid <= 1'b0;
            i_data_byte <= 8'($urandom);
            i_last_byte <= 1'($urandom);
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= lst;
        want_typed  <= typed;
        want_kind   <= k;
        want_err    <= e;
        do @(posedge i_clk); while (!o_ready);
        @(negedge i_clk);
    endtask

    function automatic void add_byte(input logic [7:0] b);
        track_bytes.insert(track_bytes.size(), b);
    endfunction

    function automatic logic [7:0] rand_data();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'h7F;
            default: return 8'($urandom_range(0, 127));
        endcase
    endfunction

    function automatic void push_vlq(input int unsigned v, input int n);
        for (int i = n - 1; i >= 0; i--)
            add_byte({(i != 0), 7'(v >> (7 * i))});
    endfunction

    function automatic void push_delta(input bit big);
        int          n;
        int unsigned v;
        if (big) begin
            push_vlq(32'h0FFF_FFFF - $urandom_range(0, 4095), 4);
        end else begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 4) : 1;
            v = $urandom & ((32'd1 << (7 * n)) - 32'd1);
            if ($urandom_range(0, 3) == 0) v = 0;
            push_vlq(v, n);
        end
    endfunction

    function automatic void push_channel_data(input logic [7:0] st);
        add_byte(rand_data());
        if (st[7:4] != mtep_pkg::NIB_PROGRAM && st[7:4] != mtep_pkg::NIB_CH_PRESS)
            add_byte(rand_data());
    endfunction

    function automatic void build_track();
        int         n_events, pick, len, cut;
        bit         big;
        logic [7:0] st;
        track_bytes.delete();
        gen_running = '0;
        big = ($urandom_range(0, 9) == 0);
        n_events = big ? 20 : $urandom_range(1, 10);
        repeat (n_events) begin
            pick = $urandom_range(0, 99);
            if (pick >= 96) begin
                repeat (4) add_byte(8'h80 | 8'($urandom_range(0, 127)));
            end else begin
                push_delta(big);
                st = {4'($urandom_range(8, 14)), 4'($urandom)};
                len = $urandom_range(0, 4);
                if (pick < 45) begin
                    gen_running = st;
                    add_byte(st);
                    push_channel_data(st);
                end else if (pick < 62) begin
                    if (gen_running == 8'h00) add_byte(rand_data());
                    else push_channel_data(gen_running);
                end else if (pick < 74) begin
                    gen_running = '0;
                    add_byte(mtep_pkg::STATUS_META);
                    add_byte(mtep_pkg::META_TEMPO);
                    add_byte(8'(mtep_pkg::TEMPO_LEN));
                    repeat (3) add_byte(8'($urandom));
                end else if (pick < 82) begin
                    gen_running = '0;
                    add_byte(mtep_pkg::STATUS_META);
                    add_byte($urandom_range(0, 1) ? mtep_pkg::META_TEMPO : 8'($urandom));
                    push_vlq(len, $urandom_range(1, 2));
                    repeat (len) add_byte(8'($urandom));
                end else if (pick < 90) begin
                    gen_running = '0;
                    add_byte($urandom_range(0, 1) ? mtep_pkg::STATUS_SYSEX
                                                  : mtep_pkg::STATUS_ESC);
                    push_vlq(len, $urandom_range(1, 2));
                    repeat (len) add_byte(8'($urandom));
                end else begin
                    case ($urandom_range(0, 3))
                        0: begin
                            st = 8'($urandom_range(8'hF1, 8'hFE));
                            add_byte((st == mtep_pkg::STATUS_ESC) ? 8'hF8 : st);
                        end
                        1: begin
                            gen_running = st;
                            add_byte(st);
                            if ($urandom_range(0, 1)) add_byte(rand_data());
                            add_byte(8'h80 | 8'($urandom));
                        end
                        2: add_byte(8'($urandom));
                        default: begin
                            gen_running = '0;
                            if ($urandom_range(0, 1)) begin
                                add_byte(mtep_pkg::STATUS_META);
                                add_byte(8'($urandom));
                            end else begin
                                add_byte(mtep_pkg::STATUS_SYSEX);
                            end
                            push_vlq($urandom_range(40, 2000), 2);
                        end
                    endcase
                end
            end
        end
        if ($urandom_range(0, 9) < 7) begin
            add_byte(8'h00);
            add_byte(mtep_pkg::STATUS_META);
            add_byte(META_END_OF_TRACK);
            add_byte(8'h00);
        end
        if ($urandom_range(0, 4) == 0) begin
            cut = $urandom_range(1, track_bytes.size());
            while (track_bytes.size() > cut) void'(track_bytes.pop_back());
        end
    endfunction

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_data_byte = '0;
        i_last_byte = 1'b0;
        want_typed  = 1'b0;
        want_kind   = mtep_pkg::KIND_END;
        want_err    = mtep_pkg::ERR_NONE;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SCRIPT[i])
            send_byte(SCRIPT[i].data, SCRIPT[i].last, SCRIPT[i].typed,
                      SCRIPT[i].kind, SCRIPT[i].err);

        for (int p = 0; p < 3; p++) begin
            snd_idle = SND_IDLE[p];
            rcv_idle = RCV_IDLE[p];
            while (n_sent < (p + 1) * ITEMS_PER_PHASE) begin
                build_track();
                foreach (track_bytes[i]) begin
                    send_byte(track_bytes[i], (i == track_bytes.size() - 1), 1'b0,
                              mtep_pkg::KIND_END, mtep_pkg::ERR_NONE);
                    n_sent++;
                end
            end
        end
        i_valid <= 1'b0;

        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (n_fail == 0 && pending_events.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
